// ===== rtl/core/matrix_vector_multiply_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Matrix-vector multiply unit: assertion macros
// Immediate-implication and next-cycle checks, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef MATRIX_VECTOR_MULTIPLY_UNIT_DEFINES_SVH
`define MATRIX_VECTOR_MULTIPLY_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define MVM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define MVM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MVM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define MVM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/core/mvm_pkg.sv =====
// ----------------------------------------------------------------------------
// Matrix-vector multiply unit: package
// Sizes, command and register codes, and the structs shared between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mvm_pkg;

   localparam int MAX_ROWS    = 64;
   localparam int MAX_COLUMNS = 64;

   // field widths
   localparam int CMD_W   = 2;
   localparam int IDX_W   = 6;
   localparam int ELEM_W  = 16;
   localparam int PROD_W  = 2 * ELEM_W;
   localparam int ACC_W   = 38;
   localparam int CNT_W   = 7;
   localparam int CSR_IDX_W = 2;

   // store geometry
   localparam int ROW_AW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_AW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int MAT_DEPTH = MAX_ROWS * MAX_COLUMNS;
   localparam int MAT_AW    = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
   localparam int LIM_W     = ($clog2(MAX_COLUMNS + 1) > CNT_W) ?
                              $clog2(MAX_COLUMNS + 1) : CNT_W;

   // command codes
   localparam logic [CMD_W-1:0] CMD_MAT_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_VEC_WRITE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPUTE   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_COUNT = 2'd1;

   localparam logic [CNT_W-1:0] ROW_COUNT_RESET    = 7'd64;
   localparam logic [CNT_W-1:0] COLUMN_COUNT_RESET = 7'd64;

   typedef struct packed {
      logic [LIM_W-1:0] rows;
      logic [LIM_W-1:0] cols;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
      logic kill;
   } mac_tag_type;

   typedef struct packed {
      logic                    done;
      logic signed [ACC_W-1:0] sum;
   } mac_out_type;

   typedef struct packed {
      logic              we;
      logic [MAT_AW-1:0] waddr;
      logic [ELEM_W-1:0] wdata;
      logic [MAT_AW-1:0] raddr;
   } mat_port_type;

   typedef struct packed {
      logic              we;
      logic [COL_AW-1:0] waddr;
      logic [ELEM_W-1:0] wdata;
      logic [COL_AW-1:0] raddr;
   } vec_port_type;

endpackage

`default_nettype wire

// ===== rtl/core/mvm_if.sv =====
// ----------------------------------------------------------------------------
// Matrix-vector multiply unit: channel interfaces
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface mvm_req_if;
   logic                             valid;
   logic                             ready;
   logic [mvm_pkg::CMD_W-1:0]        command;
   logic [mvm_pkg::IDX_W-1:0]        row_index;
   logic [mvm_pkg::IDX_W-1:0]        column_index;
   logic signed [mvm_pkg::ELEM_W-1:0] element_value;

   modport source (output valid, command, row_index, column_index, element_value,
                   input ready);
   modport sink (input valid, command, row_index, column_index, element_value,
                 output ready);
endinterface

interface mvm_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [mvm_pkg::ACC_W-1:0]  product_value;
   logic [mvm_pkg::IDX_W-1:0]         result_row;
   logic                              last_row;

   modport source (output valid, product_value, result_row, last_row, input ready);
   modport sink (input valid, product_value, result_row, last_row, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/matrix_vector_multiply_unit.sv =====
// Write commands leave the sequencer idle, so the unit stays ready for more words.
// A compute command walks every row in use: one multiply-accumulate per
// column in use (one killed element if the column count is zero) through the
// shared MAC, then a wait for the pipeline to drain and the result word load.
// Reset restores both count registers to 64; the element stores are not cleared.
// ----------------------------------------------------------------------------
// Matrix-vector multiply unit: top level
// Count registers, element stores, sequencer and shared multiply-accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_vector_multiply_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   mvm_req_if.sink                                req_channel,
   mvm_rsp_if.source                              rsp_channel,
   input  wire logic                              csr_write_enable,
   input  wire logic [mvm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [mvm_pkg::CNT_W-1:0]         csr_write_data
);

   logic [mvm_pkg::CNT_W-1:0]        row_count_ff;
   logic [mvm_pkg::CNT_W-1:0]        column_count_ff;
   mvm_pkg::cfg_type                 cfg;
   mvm_pkg::mac_tag_type             tag;
   mvm_pkg::mac_out_type             mac;
   mvm_pkg::mat_port_type            mat;
   mvm_pkg::vec_port_type            vec;
   logic [mvm_pkg::ELEM_W-1:0]       mat_rdata;
   logic [mvm_pkg::ELEM_W-1:0]       vec_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= mvm_pkg::ROW_COUNT_RESET;
         column_count_ff <= mvm_pkg::COLUMN_COUNT_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == mvm_pkg::CSR_ROW_COUNT) begin
            row_count_ff <= csr_write_data;
         end
         if (csr_index == mvm_pkg::CSR_COLUMN_COUNT) begin
            column_count_ff <= csr_write_data;
         end
      end
   end

   // clamp counts to the store size
   always_comb begin
      if (mvm_pkg::LIM_W'(row_count_ff) > mvm_pkg::LIM_W'(mvm_pkg::MAX_ROWS)) begin
         cfg.rows = mvm_pkg::LIM_W'(mvm_pkg::MAX_ROWS);
      end else begin
         cfg.rows = mvm_pkg::LIM_W'(row_count_ff);
      end
      if (mvm_pkg::LIM_W'(column_count_ff) > mvm_pkg::LIM_W'(mvm_pkg::MAX_COLUMNS)) begin
         cfg.cols = mvm_pkg::LIM_W'(mvm_pkg::MAX_COLUMNS);
      end else begin
         cfg.cols = mvm_pkg::LIM_W'(column_count_ff);
      end
   end

   mvm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .req   (req_channel),
      .rsp   (rsp_channel),
      .cfg   (cfg),
      .mac   (mac),
      .tag   (tag),
      .mat   (mat),
      .vec   (vec)
   );

   mvm_ram #(
      .DEPTH (mvm_pkg::MAT_DEPTH),
      .WIDTH (mvm_pkg::ELEM_W)
   ) u_mat_ram (
      .clock    (clock),
      .we       (mat.we),
      .waddr    (mat.waddr),
      .wdata    (mat.wdata),
      .raddr    (mat.raddr),
      .rdata_ff (mat_rdata)
   );

   mvm_ram #(
      .DEPTH (mvm_pkg::MAX_COLUMNS),
      .WIDTH (mvm_pkg::ELEM_W)
   ) u_vec_ram (
      .clock    (clock),
      .we       (vec.we),
      .waddr    (vec.waddr),
      .wdata    (vec.wdata),
      .raddr    (vec.raddr),
      .rdata_ff (vec_rdata)
   );

   mvm_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .tag      (tag),
      .mat_data (mat_rdata),
      .vec_data (vec_rdata),
      .mac      (mac)
   );

endmodule

`default_nettype wire

// ===== rtl/core/mvm_ram.sv =====
// ----------------------------------------------------------------------------
// Matrix-vector multiply unit: element store
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mvm_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             we,
   input  wire logic [$clog2(DEPTH)-1:0]         waddr,
   input  wire logic [WIDTH-1:0]                 wdata,
   input  wire logic [$clog2(DEPTH)-1:0]         raddr,
   output      logic [WIDTH-1:0]                 rdata_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

endmodule

`default_nettype wire

// ===== rtl/core/mvm_mac.sv =====
// ----------------------------------------------------------------------------
// Matrix-vector multiply unit: multiply-accumulate
// Shared 16x16 multiplier and 38-bit accumulator, one element per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mvm_mac (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire mvm_pkg::mac_tag_type                 tag,
   input  wire logic signed [mvm_pkg::ELEM_W-1:0]    mat_data,
   input  wire logic signed [mvm_pkg::ELEM_W-1:0]    vec_data,
   output      mvm_pkg::mac_out_type                 mac
);

   mvm_pkg::mac_tag_type                  s1_tag_ff;
   mvm_pkg::mac_tag_type                  s2_tag_ff;
   logic signed [mvm_pkg::PROD_W-1:0]     prod_ff;
   logic signed [mvm_pkg::PROD_W-1:0]     prod_in;
   logic signed [mvm_pkg::ACC_W-1:0]      acc_ff;
   logic signed [mvm_pkg::ACC_W-1:0]      acc_in;
   logic                                  done_ff;

   // stage 1 lines up with the store read data
   always_comb begin
      if (s1_tag_ff.kill) begin
         prod_in = '0;
      end else begin
         prod_in = mvm_pkg::PROD_W'(mat_data) * mvm_pkg::PROD_W'(vec_data);
      end
   end

   // clear on the first element of a row
   always_comb begin
      if (s2_tag_ff.first) begin
         acc_in = mvm_pkg::ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff + mvm_pkg::ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
         s2_tag_ff <= '0;
         done_ff   <= 1'b0;
      end else begin
         s1_tag_ff <= tag;
         s2_tag_ff <= s1_tag_ff;
         done_ff   <= s2_tag_ff.valid && s2_tag_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_tag_ff.valid) begin
         prod_ff <= prod_in;
      end
      if (s2_tag_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   assign mac.done = done_ff;
   assign mac.sum  = acc_ff;

endmodule

`default_nettype wire

// ===== rtl/core/mvm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Matrix-vector multiply unit: sequencer
// Handles store writes, walks rows and columns, and holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none
`include "matrix_vector_multiply_unit_defines.svh"

module mvm_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   mvm_req_if.sink                    req,
   mvm_rsp_if.source                  rsp,
   input  wire mvm_pkg::cfg_type      cfg,
   input  wire mvm_pkg::mac_out_type  mac,
   output      mvm_pkg::mac_tag_type  tag,
   output      mvm_pkg::mat_port_type mat,
   output      mvm_pkg::vec_port_type vec
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]                          state_ff, state_in;
   logic [mvm_pkg::ROW_AW-1:0]          row_ff, row_in;
   logic [mvm_pkg::COL_AW-1:0]          col_ff, col_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [mvm_pkg::ACC_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [mvm_pkg::IDX_W-1:0]           rsp_row_ff, rsp_row_in;
   logic                                rsp_last_ff, rsp_last_in;
   logic                                req_fire;
   logic                                col_last;
   logic                                row_last;
   logic                                mat_in_range;
   logic                                vec_in_range;

   assign req.ready = (state_ff == ST_IDLE);
   assign req_fire  = req.valid && req.ready;

   assign col_last = (cfg.cols == '0) ||
                     (mvm_pkg::LIM_W'(col_ff) + mvm_pkg::LIM_W'(1) == cfg.cols);
   assign row_last = (mvm_pkg::LIM_W'(row_ff) + mvm_pkg::LIM_W'(1) == cfg.rows);

   assign mat_in_range = (32'(req.row_index) < 32'(mvm_pkg::MAX_ROWS)) &&
                         (32'(req.column_index) < 32'(mvm_pkg::MAX_COLUMNS));
   assign vec_in_range = (32'(req.column_index) < 32'(mvm_pkg::MAX_COLUMNS));

   // store ports
   always_comb begin
      mat.we    = req_fire && (req.command == mvm_pkg::CMD_MAT_WRITE) && mat_in_range;
      mat.waddr = mvm_pkg::MAT_AW'(req.row_index) * mvm_pkg::MAT_AW'(mvm_pkg::MAX_COLUMNS)
                  + mvm_pkg::MAT_AW'(req.column_index);
      mat.wdata = req.element_value;
      mat.raddr = mvm_pkg::MAT_AW'(row_ff) * mvm_pkg::MAT_AW'(mvm_pkg::MAX_COLUMNS)
                  + mvm_pkg::MAT_AW'(col_ff);
      vec.we    = req_fire && (req.command == mvm_pkg::CMD_VEC_WRITE) && vec_in_range;
      vec.waddr = mvm_pkg::COL_AW'(req.column_index);
      vec.wdata = req.element_value;
      vec.raddr = col_ff;
   end

   // one element per cycle while walking a row; zero columns run one killed element
   always_comb begin
      tag.valid = (state_ff == ST_RUN);
      tag.first = (col_ff == '0);
      tag.last  = col_last;
      tag.kill  = (cfg.cols == '0);
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_value_in = rsp_value_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req.command == mvm_pkg::CMD_COMPUTE) && (cfg.rows != '0)) begin
               row_in   = '0;
               col_in   = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (col_last) begin
               state_in = ST_WAIT;
            end else begin
               col_in = col_ff + mvm_pkg::COL_AW'(1);
            end
         end
         ST_WAIT: begin
            if (mac.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // load the result word once the output register is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = mac.sum;
               rsp_row_in   = mvm_pkg::IDX_W'(row_ff);
               rsp_last_in  = row_last;
               col_in       = '0;
               if (row_last) begin
                  state_in = ST_IDLE;
               end else begin
                  row_in   = row_ff + mvm_pkg::ROW_AW'(1);
                  state_in = ST_RUN;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.product_value = rsp_value_ff;
   assign rsp.result_row    = rsp_row_ff;
   assign rsp.last_row      = rsp_last_ff;

   `MVM_ASSERT_IMPLY(a_done_in_wait, clock, reset, mac.done, state_ff == ST_WAIT, "row sum finished outside wait")
   `MVM_ASSERT_NEXT(a_emit_loads, clock, reset, (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp.ready), rsp_valid_ff, "free output register not loaded")
   `MVM_ASSERT_NEXT(a_start_first, clock, reset, req_fire && (req.command == mvm_pkg::CMD_COMPUTE) && (cfg.rows != '0), tag.valid && tag.first && (row_ff == '0), "compute did not start at row zero column zero")

endmodule

`default_nettype wire

// ===== bench/tb_matrix_vector_multiply_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Matrix-vector multiply unit: testbench
// Loads matrix and vector elements over the command channel, then issues
// compute commands under changing row and column counts. Every result word
// is checked against a dot-product predictor kept in step with each accepted
// command word, or on typed steps against a table product. Both channels
// idle at random, and the result side stalls once for a long stretch.
// ----------------------------------------------------------------------------

module tb_matrix_vector_multiply_unit;

   localparam logic [mvm_pkg::CMD_W-1:0]        CMD_RESERVED = 2'd3;
   localparam logic [mvm_pkg::CSR_IDX_W-1:0]    CSR_SPARE_LO = 2'd2;
   localparam logic [mvm_pkg::CSR_IDX_W-1:0]    CSR_SPARE_HI = 2'd3;
   localparam logic signed [mvm_pkg::ACC_W-1:0] NO_PRODUCT   = '0;
   localparam int MAX_GAP        = 18;
   localparam int LONG_STALL     = 400;
   localparam int SETTLE_CYCLES  = 24;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_WORDS   = 190;
   localparam int DIRECTED_STEPS = 25;
   localparam int VECTOR_TAG     = mvm_pkg::MAX_ROWS * mvm_pkg::MAX_COLUMNS;

   typedef enum logic {STEP_WORD, STEP_CSR} step_kind_type;

   typedef struct packed {
      step_kind_type                        kind;
      logic [mvm_pkg::CMD_W-1:0]            command;
      logic [mvm_pkg::IDX_W-1:0]            row;
      logic [mvm_pkg::IDX_W-1:0]            col;
      logic [mvm_pkg::ELEM_W-1:0]           value;
      logic [mvm_pkg::CSR_IDX_W-1:0]        csr_sel;
      logic [mvm_pkg::CNT_W-1:0]            csr_data;
      logic                                 typed;
      logic signed [mvm_pkg::ACC_W-1:0]     product;
   } directed_step_type;

   typedef struct packed {
      logic signed [mvm_pkg::ACC_W-1:0] product;
      logic [mvm_pkg::IDX_W-1:0]        row;
      logic                             last;
   } row_result_type;

   logic clock = 1'b0;
   logic reset;
   logic                          csr_write_enable;
   logic [mvm_pkg::CSR_IDX_W-1:0] csr_index;
   logic [mvm_pkg::CNT_W-1:0]     csr_write_data;

   mvm_req_if req_ch();
   mvm_rsp_if rsp_ch();

   matrix_vector_multiply_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_ch),
      .rsp_channel      (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state, advanced at each accepted command word and register write
   logic [mvm_pkg::ELEM_W-1:0] matrix_mirror [mvm_pkg::MAX_ROWS][mvm_pkg::MAX_COLUMNS];
   logic [mvm_pkg::ELEM_W-1:0] vector_mirror [mvm_pkg::MAX_COLUMNS];
   logic [mvm_pkg::CNT_W-1:0]  row_count_mirror    = mvm_pkg::ROW_COUNT_RESET;
   logic [mvm_pkg::CNT_W-1:0]  column_count_mirror = mvm_pkg::COLUMN_COUNT_RESET;
   row_result_type             expected_rows [$];

   // entries already written, so that no compute reads an unwritten one
   bit matrix_loaded [mvm_pkg::MAX_ROWS][mvm_pkg::MAX_COLUMNS];
   bit vector_loaded [mvm_pkg::MAX_COLUMNS];

   bit                               typed_check = 1'b0;
   logic signed [mvm_pkg::ACC_W-1:0] typed_product;
   bit idle_free    = 1'b0;
   bit random_phase = 1'b0;
   bit stall_done   = 1'b0;
   int error_count     = 0;
   int words_accepted  = 0;
   int results_checked = 0;
   int csr_writes      = 0;
   int stalled_cycles  = 0;

   directed_step_type directed_table [DIRECTED_STEPS] = '{
      '{STEP_CSR,  mvm_pkg::CMD_MAT_WRITE, 6'd0,  6'd0,  16'h0000,
        mvm_pkg::CSR_ROW_COUNT,    7'd1,  1'b0, NO_PRODUCT},
      '{STEP_CSR,  mvm_pkg::CMD_MAT_WRITE, 6'd0,  6'd0,  16'h0000,
        mvm_pkg::CSR_COLUMN_COUNT, 7'd2,  1'b0, NO_PRODUCT},
      '{STEP_CSR,  mvm_pkg::CMD_MAT_WRITE, 6'd0,  6'd0,  16'h0000,
        CSR_SPARE_LO,              7'h7F, 1'b0, NO_PRODUCT},
      '{STEP_CSR,  mvm_pkg::CMD_MAT_WRITE, 6'd0,  6'd0,  16'h0000,
        CSR_SPARE_HI,              7'd0,  1'b0, NO_PRODUCT},
      '{STEP_WORD, mvm_pkg::CMD_MAT_WRITE, 6'd0,  6'd0,  16'h7FFF,
        mvm_pkg::CSR_ROW_COUNT,    7'd0,  1'b0, NO_PRODUCT},
      '{STEP_WORD, mvm_pkg::CMD_MAT_WRITE, 6'd0,  6'd1,  16'h8000,
        mvm_pkg::CSR_ROW_COUNT,    7'd0,  1'b0, NO_PRODUCT},
      '{STEP_WORD, mvm_pkg::CMD_VEC_WRITE, 6'd63, 6'd0,  16'h7FFF,
        mvm_pkg::CSR_ROW_COUNT,    7'd0,  1'b0, NO_PRODUCT},
      '{STEP_WORD, mvm_pkg::CMD_VEC_WRITE, 6'd0,  6'd1,  16'h8000,
        mvm_pkg::CSR_ROW_COUNT,    7'd0,  1'b0, NO_PRODUCT},
      '{STEP_WORD, mvm_pkg::CMD_COMPUTE,   6'd0,  6'd0,  16'h0000,
        mvm_pkg::CSR_ROW_COUNT,    7'd0,  1'b1, mvm_pkg::ACC_W'(2147418113)},
      '{STEP_WORD, mvm_pkg::CMD_VEC_WRITE, 6'd63, 6'd1,  16'h7FFF,
        mvm_pkg::CSR_ROW_COUNT,    7'd0,  1'b0, NO_PRODUCT},
      '{STEP_WORD, mvm_pkg::CMD_COMPUTE,   6'd63, 6'd63, 16'hFFFF,
        mvm_pkg::CSR_ROW_COUNT,    7'd0,  1'b1, mvm_pkg::ACC_W'(-32767)},
      // reserved code aimed at entries in use: must leave both stores alone
      '{STEP_WORD, CMD_RESERVED,           6'd0,  6'd0,  16'h0000,
        mvm_pkg::CSR_ROW_COUNT,    7'd0,  1'b0, NO_PRODUCT},
      '{STEP_WORD, mvm_pkg::CMD_COMPUTE,   6'd0,  6'd0,  16'h0000,
        mvm_pkg::CSR_ROW_COUNT,    7'd0,  1'b1, mvm_pkg::ACC_W'(-32767)},
      '{STEP_WORD, mvm_pkg::CMD_MAT_WRITE, 6'd63, 6'd63, 16'h0100,
        mvm_pkg::CSR_ROW_COUNT,    7'd0,  1'b0, NO_PRODUCT},
      '{STEP_WORD, mvm_pkg::CMD_VEC_WRITE, 6'd0,  6'd63, 16'hFF00,
        mvm_pkg::CSR_ROW_COUNT,    7'd0,  1'b0, NO_PRODUCT},
      '{STEP_WORD, mvm_pkg::CMD_MAT_WRITE, 6'd0,  6'd0,  16'h0000,
        mvm_pkg::CSR_ROW_COUNT,    7'd0,  1'b0, NO_PRODUCT},
      '{STEP_WORD, mvm_pkg::CMD_COMPUTE,   6'd0,  6'd0,  16'h0000,
        mvm_pkg::CSR_ROW_COUNT,    7'd0,  1'b1, mvm_pkg::ACC_W'(-1073709056)},
      '{STEP_CSR,  mvm_pkg::CMD_MAT_WRITE, 6'd0,  6'd0,  16'h0000,
        mvm_pkg::CSR_COLUMN_COUNT, 7'd0,  1'b0, NO_PRODUCT},
      '{STEP_WORD, mvm_pkg::CMD_COMPUTE,   6'd0,  6'd0,  16'h0000,
        mvm_pkg::CSR_ROW_COUNT,    7'd0,  1'b1, NO_PRODUCT},
      '{STEP_CSR,  mvm_pkg::CMD_MAT_WRITE, 6'd0,  6'd0,  16'h0000,
        mvm_pkg::CSR_ROW_COUNT,    7'd0,  1'b0, NO_PRODUCT},
      '{STEP_WORD, mvm_pkg::CMD_COMPUTE,   6'd0,  6'd0,  16'h0000,
        mvm_pkg::CSR_ROW_COUNT,    7'd0,  1'b0, NO_PRODUCT},
      '{STEP_WORD, mvm_pkg::CMD_MAT_WRITE, 6'd1,  6'd0,  16'h8000,
        mvm_pkg::CSR_ROW_COUNT,    7'd0,  1'b0, NO_PRODUCT},
      '{STEP_CSR,  mvm_pkg::CMD_MAT_WRITE, 6'd0,  6'd0,  16'h0000,
        mvm_pkg::CSR_ROW_COUNT,    7'd2,  1'b0, NO_PRODUCT},
      '{STEP_CSR,  mvm_pkg::CMD_MAT_WRITE, 6'd0,  6'd0,  16'h0000,
        mvm_pkg::CSR_COLUMN_COUNT, 7'd1,  1'b0, NO_PRODUCT},
      '{STEP_WORD, mvm_pkg::CMD_COMPUTE,   6'd0,  6'd0,  16'h0000,
        mvm_pkg::CSR_ROW_COUNT,    7'd0,  1'b0, NO_PRODUCT}
   };

   task automatic predict_dot_products(input logic [mvm_pkg::CMD_W-1:0] cmd,
                                       input logic [mvm_pkg::IDX_W-1:0] row,
                                       input logic [mvm_pkg::IDX_W-1:0] col,
                                       input logic [mvm_pkg::ELEM_W-1:0] value);
      int rows_eff;
      int cols_eff;
      logic signed [mvm_pkg::ACC_W-1:0]  acc;
      logic signed [mvm_pkg::PROD_W-1:0] term;
      row_result_type res;
      rows_eff = (row_count_mirror > mvm_pkg::MAX_ROWS) ? mvm_pkg::MAX_ROWS :
                 int'(row_count_mirror);
      cols_eff = (column_count_mirror > mvm_pkg::MAX_COLUMNS) ? mvm_pkg::MAX_COLUMNS :
                 int'(column_count_mirror);
      case (cmd)
         mvm_pkg::CMD_MAT_WRITE: matrix_mirror[row][col] = value;
         mvm_pkg::CMD_VEC_WRITE: vector_mirror[col] = value;
         mvm_pkg::CMD_COMPUTE: begin
            for (int r = 0; r < rows_eff; r++) begin
               acc = '0;
               for (int c = 0; c < cols_eff; c++) begin
                  term = $signed(matrix_mirror[r][c]) * $signed(vector_mirror[c]);
                  acc = acc + term;
               end
               res.product = typed_check ? typed_product : acc;
               res.row     = mvm_pkg::IDX_W'(r);
               res.last    = (r == rows_eff - 1);
               expected_rows.push_back(res);
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_result_word();
      row_result_type want;
      results_checked++;
      if (expected_rows.size() == 0) begin
         $error("result word for row %0d with no expectation waiting", rsp_ch.result_row);
         error_count++;
      end else begin
         want = expected_rows.pop_front();
         if (rsp_ch.product_value !== want.product) begin
            $error("product_value: expected %0d, got %0d", want.product, rsp_ch.product_value);
            error_count++;
         end
         if (rsp_ch.result_row !== want.row) begin
            $error("result_row: expected %0d, got %0d", want.row, rsp_ch.result_row);
            error_count++;
         end
         if (rsp_ch.last_row !== want.last) begin
            $error("last_row: expected %0d, got %0d", want.last, rsp_ch.last_row);
            error_count++;
         end
      end
   endtask

   // check results before predicting, so a compute accepted on this edge
   // cannot be matched against an older result word
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            check_result_word();
         if (req_ch.valid && req_ch.ready)
            predict_dot_products(req_ch.command, req_ch.row_index, req_ch.column_index,
                                 req_ch.element_value);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          csr_write_enable) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                  stalled_cycles, expected_rows.size());
         $display("RESULT: ERROR");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   // result side: random hold before each word, one long hold mid-compute
   initial begin : result_receiver
      int unsigned hold;
      rsp_ch.ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         hold = idle_free ? 0 : $urandom_range(0, MAX_GAP);
         if (!stall_done && random_phase && expected_rows.size() >= 4) begin
            hold = LONG_STALL;
            stall_done = 1'b1;
         end
         if (hold != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         @(negedge clock);
      end
   end

   task automatic send_word(input logic [mvm_pkg::CMD_W-1:0] cmd,
                            input logic [mvm_pkg::IDX_W-1:0] row,
                            input logic [mvm_pkg::IDX_W-1:0] col,
                            input logic [mvm_pkg::ELEM_W-1:0] value);
      int unsigned gap;
      gap = idle_free ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.command       <= cmd;
      req_ch.row_index     <= row;
      req_ch.column_index  <= col;
      req_ch.element_value <= value;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      @(negedge clock);
      if (cmd == mvm_pkg::CMD_MAT_WRITE)
         matrix_loaded[row][col] = 1'b1;
      else if (cmd == mvm_pkg::CMD_VEC_WRITE)
         vector_loaded[col] = 1'b1;
      if (cmd != CMD_RESERVED)
         words_accepted++;
   endtask

   // drop valid and let the block drain before touching the registers
   task automatic wait_until_idle();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (expected_rows.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [mvm_pkg::CSR_IDX_W-1:0] sel,
                                 input logic [mvm_pkg::CNT_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= sel;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      if (sel == mvm_pkg::CSR_ROW_COUNT)
         row_count_mirror = data;
      else if (sel == mvm_pkg::CSR_COLUMN_COUNT)
         column_count_mirror = data;
      csr_writes++;
   endtask

   // reserved code or a write to any entry of either store
   task automatic send_loose_word();
      case ($urandom_range(0, 3))
         0: send_word(CMD_RESERVED, mvm_pkg::IDX_W'($urandom), mvm_pkg::IDX_W'($urandom),
                      mvm_pkg::ELEM_W'($urandom));
         1: send_word(mvm_pkg::CMD_VEC_WRITE, mvm_pkg::IDX_W'($urandom),
                      mvm_pkg::IDX_W'($urandom), mvm_pkg::ELEM_W'($urandom));
         default: send_word(mvm_pkg::CMD_MAT_WRITE, mvm_pkg::IDX_W'($urandom),
                            mvm_pkg::IDX_W'($urandom), mvm_pkg::ELEM_W'($urandom));
      endcase
   endtask

   // one load/compute pass: set sizes, fill what the compute will read,
   // overwrite a few entries, compute, then trail a few stray words
   task automatic run_sequence(input int seq_idx);
      logic [mvm_pkg::CNT_W-1:0] rows_val;
      logic [mvm_pkg::CNT_W-1:0] cols_val;
      int rows_eff;
      int cols_eff;
      int fill [$];
      if (seq_idx == 0) begin
         rows_val = mvm_pkg::CNT_W'(mvm_pkg::MAX_ROWS);
         cols_val = 7'd1;
      end else if (seq_idx == 1) begin
         rows_val = 7'd1;
         cols_val = mvm_pkg::CNT_W'(mvm_pkg::MAX_COLUMNS);
      end else begin
         case ($urandom_range(0, 19))
            0: begin
               rows_val = 7'd0;
               cols_val = mvm_pkg::CNT_W'($urandom_range(1, 8));
            end
            1: begin
               rows_val = mvm_pkg::CNT_W'($urandom_range(1, 8));
               cols_val = 7'd0;
            end
            2: begin
               rows_val = mvm_pkg::CNT_W'($urandom_range(mvm_pkg::MAX_ROWS + 1, 127));
               cols_val = 7'd1;
            end
            3: begin
               rows_val = 7'd1;
               cols_val = mvm_pkg::CNT_W'($urandom_range(mvm_pkg::MAX_COLUMNS + 1, 127));
            end
            default: begin
               rows_val = mvm_pkg::CNT_W'($urandom_range(1, 8));
               cols_val = mvm_pkg::CNT_W'($urandom_range(1, 8));
            end
         endcase
      end
      wait_until_idle();
      write_register(mvm_pkg::CSR_ROW_COUNT, rows_val);
      write_register(mvm_pkg::CSR_COLUMN_COUNT, cols_val);
      idle_free = ($urandom_range(0, 3) == 0);
      rows_eff = (rows_val > mvm_pkg::MAX_ROWS) ? mvm_pkg::MAX_ROWS : int'(rows_val);
      cols_eff = (cols_val > mvm_pkg::MAX_COLUMNS) ? mvm_pkg::MAX_COLUMNS : int'(cols_val);

      for (int r = 0; r < rows_eff; r++)
         for (int c = 0; c < cols_eff; c++)
            if (!matrix_loaded[r][c])
               fill.push_back(r * mvm_pkg::MAX_COLUMNS + c);
      for (int c = 0; c < cols_eff; c++)
         if (!vector_loaded[c])
            fill.push_back(VECTOR_TAG + c);
      fill.shuffle();
      foreach (fill[i]) begin
         if ($urandom_range(0, 9) == 0)
            send_loose_word();
         if (fill[i] >= VECTOR_TAG)
            send_word(mvm_pkg::CMD_VEC_WRITE, mvm_pkg::IDX_W'($urandom),
                      mvm_pkg::IDX_W'(fill[i] - VECTOR_TAG), mvm_pkg::ELEM_W'($urandom));
         else
            send_word(mvm_pkg::CMD_MAT_WRITE, mvm_pkg::IDX_W'(fill[i] / mvm_pkg::MAX_COLUMNS),
                      mvm_pkg::IDX_W'(fill[i] % mvm_pkg::MAX_COLUMNS),
                      mvm_pkg::ELEM_W'($urandom));
      end

      repeat ($urandom_range(1, 6)) begin
         if (cols_eff != 0 && (rows_eff == 0 || $urandom_range(0, 2) == 0))
            send_word(mvm_pkg::CMD_VEC_WRITE, mvm_pkg::IDX_W'($urandom),
                      mvm_pkg::IDX_W'($urandom_range(0, cols_eff - 1)),
                      mvm_pkg::ELEM_W'($urandom));
         else if (rows_eff != 0 && cols_eff != 0)
            send_word(mvm_pkg::CMD_MAT_WRITE, mvm_pkg::IDX_W'($urandom_range(0, rows_eff - 1)),
                      mvm_pkg::IDX_W'($urandom_range(0, cols_eff - 1)),
                      mvm_pkg::ELEM_W'($urandom));
         else
            send_loose_word();
      end

      send_word(mvm_pkg::CMD_COMPUTE, mvm_pkg::IDX_W'($urandom), mvm_pkg::IDX_W'($urandom),
                mvm_pkg::ELEM_W'($urandom));
      repeat ($urandom_range(1, 3)) send_loose_word();
   endtask

   initial begin : stimulus
      int seq_idx;
      int random_from;
      seq_idx = 0;
      reset                = 1'b1;
      csr_write_enable     = 1'b0;
      csr_index            = mvm_pkg::CSR_ROW_COUNT;
      csr_write_data       = '0;
      req_ch.valid         = 1'b0;
      req_ch.command       = mvm_pkg::CMD_MAT_WRITE;
      req_ch.row_index     = '0;
      req_ch.column_index  = '0;
      req_ch.element_value = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_table[i]) begin
         if (directed_table[i].kind == STEP_CSR) begin
            wait_until_idle();
            write_register(directed_table[i].csr_sel, directed_table[i].csr_data);
         end else begin
            typed_check   = directed_table[i].typed;
            typed_product = directed_table[i].product;
            send_word(directed_table[i].command, directed_table[i].row,
                      directed_table[i].col, directed_table[i].value);
            typed_check = 1'b0;
         end
      end

      random_phase = 1'b1;
      random_from  = words_accepted;
      while (words_accepted - random_from < RANDOM_WORDS) begin
         run_sequence(seq_idx);
         seq_idx++;
      end
      wait_until_idle();

      $display("Covered %0d command words over %0d random load/compute passes,",
               words_accepted, seq_idx);
      $display("%0d register writes, %0d result words checked; long result-side hold %s.",
               csr_writes, results_checked, stall_done ? "applied" : "not reached");
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
